@@ rtl/scp_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scp_pkg
// Shared types, codes and character helpers for the serial command parser.
// ---------------------------------------------------------------------------
package scp_pkg;

	localparam logic [7:0] NL_CHAR   = 8'h0A;
	localparam logic [7:0] BANG_CHAR = 8'h21;

	// Sequencer position width: covers store positions 0..24.
	localparam int SEQ_W = 5;

	// Command words, left aligned in 64 bits, first character on top.
	localparam logic [63:0] W_DEVEUI  = {"DEVEUI=", 8'h00};
	localparam logic [63:0] W_JOINEUI = "JOINEUI=";
	localparam logic [63:0] W_JOIN    = {"JOIN", 32'h0};
	localparam logic [63:0] W_PRINT   = {"PRINT", 24'h0};
	localparam logic [63:0] W_STATUS  = {"STATUS", 16'h0};

	localparam logic [3:0] L_DEVEUI  = 4'd7;
	localparam logic [3:0] L_JOINEUI = 4'd8;
	localparam logic [3:0] L_JOIN    = 4'd4;
	localparam logic [3:0] L_PRINT   = 4'd5;
	localparam logic [3:0] L_STATUS  = 4'd6;

	localparam logic [SEQ_W-1:0] EUI_START_DEV  = 5'd8;
	localparam logic [SEQ_W-1:0] EUI_START_JOIN = 5'd9;

	typedef enum logic [2:0] {
		EV_UNKNOWN  = 3'd0,
		EV_SET_DEV  = 3'd1,
		EV_SET_JOIN = 3'd2,
		EV_JOIN     = 3'd3,
		EV_PRINT    = 3'd4,
		EV_STATUS   = 3'd5,
		EV_REJECTED = 3'd6,
		EV_OVERFLOW = 3'd7
	} event_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_DECIDE,
		ST_DECODE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             take;
		logic             clear;
		logic             rd_en;
		logic [SEQ_W-1:0] rd_pos;
		logic             chk_en;
		logic [3:0]       chk_pos;
		logic             dec_en;
		logic             dec_lo;
		logic             emit;
	} cmd_t;

	typedef struct packed {
		logic line_end;
		logic out_free;
		logic need_eui;
		logic start_join;
	} sts_t;

	// True when byte b agrees with character idx of word w, or idx is past its end.
	function automatic logic pfx_ok(input logic [63:0] w, input logic [3:0] len,
			input logic [2:0] idx, input logic [7:0] b);
		logic [7:0] ch;
		ch = w[63 - 8*idx -: 8];
		return ({1'b0, idx} >= len) || (b == ch);
	endfunction

	// Hex digit value, mod 256; non-hex bytes follow the same arithmetic.
	function automatic logic [7:0] nibble_of(input logic [7:0] c);
		logic [7:0] u;
		u = c;
		if (c >= 8'h30 && c <= 8'h39) begin
			return c - 8'h30;
		end
		if (c >= 8'h61 && c <= 8'h7A) begin
			u = c - 8'h20;
		end
		return u - 8'd55;
	endfunction

endpackage

@@ rtl/scp_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scp_if
// Valid/ready channels: received bytes in, parse events out.
// ---------------------------------------------------------------------------
interface scp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface scp_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [63:0] eui_value;
	logic [5:0]  discarded_count;

	modport source (output valid, output event_res, output eui_value,
		output discarded_count, input ready);
	modport sink (input valid, input event_res, input eui_value,
		input discarded_count, output ready);
endinterface

@@ rtl/scp_dpath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scp_dpath
// Line store, fill count, prefix match flags, hex decoder and result register.
// ---------------------------------------------------------------------------
module scp_dpath import scp_pkg::*; #(
	parameter int LINE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [7:0]  rx_byte,
	input  logic        res_ready,
	output logic        res_valid,
	output logic [2:0]  event_res,
	output logic [63:0] eui_value,
	output logic [5:0]  discarded_count
);

	localparam int ADDR_W = $clog2(LINE_DEPTH);
	localparam int FILL_W = $clog2(LINE_DEPTH + 1);

	logic [7:0]        mem [LINE_DEPTH];
	logic [LINE_DEPTH-1:0] wr_seen_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] len_q;
	logic [7:0]        rd_data_q;
	logic              bang_q;
	logic              dev_q, jeui_q, join_q, print_q, status_q;
	logic [7:0]        hi_q;
	logic [63:0]       acc_q;
	logic              res_valid_q;
	event_t            ev_q;
	logic [63:0]       eui_q;
	logic [5:0]        cnt_q;

	logic              full;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [2:0]        cidx;
	logic              line_ok;
	event_t            ev_line;
	logic [7:0]        lo_nib;

	assign full    = (fill_q == FILL_W'(LINE_DEPTH));
	assign wr_addr = full ? '0 : fill_q[ADDR_W-1:0];
	assign rd_addr = ADDR_W'(cmd.rd_pos);
	assign cidx    = 3'(cmd.chk_pos - 4'd1);
	assign line_ok = (len_q >= FILL_W'(2)) && bang_q;
	assign lo_nib  = nibble_of(rd_data_q);

	assign sts.line_end   = !full && (rx_byte == NL_CHAR);
	assign sts.out_free   = !res_valid_q || res_ready;
	assign sts.need_eui   = line_ok && (dev_q || jeui_q);
	assign sts.start_join = !dev_q;

	always_comb begin
		if (!line_ok)      ev_line = EV_REJECTED;
		else if (dev_q)    ev_line = EV_SET_DEV;
		else if (jeui_q)   ev_line = EV_SET_JOIN;
		else if (join_q)   ev_line = EV_JOIN;
		else if (print_q)  ev_line = EV_PRINT;
		else if (status_q) ev_line = EV_STATUS;
		else               ev_line = EV_UNKNOWN;
	end

	// store array, no reset; wr_seen_q stands in for the cleared contents
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mem[wr_addr] <= rx_byte;
		end
		if (cmd.rd_en) begin
			rd_data_q <= wr_seen_q[rd_addr] ? mem[rd_addr] : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_seen_q <= '0;
			fill_q    <= '0;
		end else if (cmd.take) begin
			wr_seen_q[wr_addr] <= 1'b1;
			if (full) begin
				fill_q <= FILL_W'(1);
			end else if (rx_byte == NL_CHAR) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// line length, match flags and decode accumulator
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			len_q    <= fill_q + FILL_W'(1);
			bang_q   <= 1'b0;
			dev_q    <= 1'b1;
			jeui_q   <= 1'b1;
			join_q   <= 1'b1;
			print_q  <= 1'b1;
			status_q <= 1'b1;
			acc_q    <= '0;
		end
		if (cmd.chk_en) begin
			if (cmd.chk_pos == 4'd0) begin
				bang_q <= (rd_data_q == BANG_CHAR);
			end else begin
				dev_q    <= dev_q    && pfx_ok(W_DEVEUI,  L_DEVEUI,  cidx, rd_data_q);
				jeui_q   <= jeui_q   && pfx_ok(W_JOINEUI, L_JOINEUI, cidx, rd_data_q);
				join_q   <= join_q   && pfx_ok(W_JOIN,    L_JOIN,    cidx, rd_data_q);
				print_q  <= print_q  && pfx_ok(W_PRINT,   L_PRINT,   cidx, rd_data_q);
				status_q <= status_q && pfx_ok(W_STATUS,  L_STATUS,  cidx, rd_data_q);
			end
		end
		if (cmd.dec_en) begin
			if (cmd.dec_lo) begin
				acc_q <= {acc_q[55:0], ({hi_q[3:0], 4'h0} | lo_nib)};
			end else begin
				hi_q <= lo_nib;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((cmd.take && full) || cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && full) begin
			ev_q  <= EV_OVERFLOW;
			eui_q <= '0;
			cnt_q <= 6'(LINE_DEPTH);
		end else if (cmd.emit) begin
			ev_q  <= ev_line;
			eui_q <= (ev_line == EV_SET_DEV || ev_line == EV_SET_JOIN) ? acc_q : '0;
			cnt_q <= (ev_line == EV_REJECTED) ? 6'(len_q) : '0;
		end
	end

	assign res_valid       = res_valid_q;
	assign event_res       = ev_q;
	assign eui_value       = eui_q;
	assign discarded_count = cnt_q;

endmodule

@@ rtl/scp_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scp_ctrl
// Sequencer: store reads for prefix match, then for the hex decode.
// ---------------------------------------------------------------------------
module scp_ctrl import scp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  sts_t sts,
	output cmd_t cmd,
	output logic rx_ready
);

	localparam logic [SEQ_W-1:0] MATCH_LAST  = 5'd9;
	localparam logic [SEQ_W-1:0] DECODE_LAST = 5'd16;

	state_t           state_q, state_d;
	logic [SEQ_W-1:0] seq_q;
	logic [SEQ_W-1:0] start;

	assign start = sts.start_join ? EUI_START_JOIN : EUI_START_DEV;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seq_q   <= '0;
		end else begin
			state_q <= state_d;
			seq_q   <= (state_d != state_q) ? '0 : seq_q + 5'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && sts.line_end) state_d = ST_MATCH;
			end
			ST_MATCH: begin
				if (seq_q == MATCH_LAST) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = sts.need_eui ? ST_DECODE : ST_IDLE;
			end
			ST_DECODE: begin
				if (seq_q == DECODE_LAST) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		rx_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rx_ready  = sts.out_free;
				cmd.take  = take;
				cmd.clear = take && sts.line_end;
			end
			ST_MATCH: begin
				cmd.rd_en   = (seq_q != MATCH_LAST);
				cmd.rd_pos  = seq_q;
				cmd.chk_en  = (seq_q != '0);
				cmd.chk_pos = 4'(seq_q - 5'd1);
			end
			ST_DECIDE: begin
				cmd.emit = !sts.need_eui;
			end
			ST_DECODE: begin
				cmd.rd_en  = (seq_q != DECODE_LAST);
				cmd.rd_pos = seq_q + start;
				cmd.dec_en = (seq_q != '0);
				cmd.dec_lo = !seq_q[0];
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/serial_command_line_parser_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_command_line_parser_unit
// Collects serial bytes into lines and reports parsed '!' commands.
// ---------------------------------------------------------------------------
// Usage:
//   rx  : one received byte per beat (valid/ready).
//   res : one event beat per newline-terminated line, and one per byte that
//         arrives with the store full (overflow, counts LINE_DEPTH).
//   Ordinary bytes are written to the store in their accept cycle and give
//   no event. A newline starts a check: the match state reads store positions 0..8
//   one per cycle for the '!' and prefix compare, a decide state follows, and for
//   DEVEUI=/JOINEUI= a decode state then reads 16 hex characters through the
//   single store read port, and an emit state loads the event register.
//   rx is not ready during a line check.
//   Throughput: one byte per cycle between newlines, unless stalled.
//   Stall: the event register holds the beat; rx drops ready while it is
//   full and not being taken.
//   Reset: fill count and sequencer cleared; store entries read as zero
//   until written (per-entry written flags), so no clearing pass is needed.
// ---------------------------------------------------------------------------
module serial_command_line_parser_unit import scp_pkg::*; #(
	parameter int LINE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	scp_rx_if.sink      rx,
	scp_res_if.source   res
);

	cmd_t cmd;
	sts_t sts;
	logic take;

	// a byte is taken when both handshake lines are high
	assign take = rx.valid && rx.ready;

	scp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.sts      (sts),
		.cmd      (cmd),
		.rx_ready (rx.ready)
	);

	scp_dpath #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.rx_byte         (rx.rx_byte),
		.res_ready       (res.ready),
		.res_valid       (res.valid),
		.event_res       (res.event_res),
		.eui_value       (res.eui_value),
		.discarded_count (res.discarded_count)
	);

endmodule

@@ rtl/scp_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scp_port_checker
// Port-level checks on the parser event channel, bound to the top level.
// ---------------------------------------------------------------------------
module scp_port_checker import scp_pkg::*; #(
	parameter int LINE_DEPTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  event_res,
	input logic [63:0] eui_value,
	input logic [5:0]  discarded_count
);

	// stalled event beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(event_res)
			&& $stable(eui_value) && $stable(discarded_count))
		else $error("event beat changed while stalled");

	a_eui_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !(event_res == EV_SET_DEV || event_res == EV_SET_JOIN)
			|-> eui_value == '0)
		else $error("eui nonzero on non-set event");

	a_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !(event_res == EV_REJECTED || event_res == EV_OVERFLOW)
			|-> discarded_count == '0)
		else $error("discard count nonzero on accepted line");

	a_ovf_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res == EV_OVERFLOW |-> discarded_count == 6'(LINE_DEPTH))
		else $error("overflow count differs from store depth");

	a_rx_block: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !rx_ready)
		else $error("byte taken while event register stalled");

endmodule

bind serial_command_line_parser_unit scp_port_checker #(
	.LINE_DEPTH (LINE_DEPTH)
) u_scp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rx_ready        (rx.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.event_res       (res.event_res),
	.eui_value       (res.eui_value),
	.discarded_count (res.discarded_count)
);
